### sv/i2c_master_bit_engine_assert.svh
// assertion macros for the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2c bit engine assertion failed");
`define ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("i2c bit engine forbidden condition");
`else
`define ASSERT_CLK(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, expr)
`endif
`endif

### sv/i2cm_pkg.sv
// types, constants and pin sequence functions of the i2c master bit engine
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_RDACK = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_START_FAIL = 2'd1,
    STATUS_NACK       = 2'd2
  } status_e;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [4:0]  READ_LAST_PHASE   = 5'd15;
  localparam logic [4:0]  WRITE_BIT_PHASES  = 5'd24;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } pins_t;

  function automatic logic [4:0] phase_count(cmd_e c);
    logic [4:0] n;
    case (c)
      CMD_START: n = 5'd3;
      CMD_STOP:  n = 5'd4;
      CMD_WRITE: n = 5'd25;
      CMD_READ:  n = 5'd16;
      CMD_RDACK: n = 5'd3;
      CMD_ACK:   n = 5'd4;
      CMD_NACK:  n = 5'd4;
      default:   n = 5'd3;
    endcase
    return n;
  endfunction

  // pin change made when phase p of command c begins
  function automatic pins_t apply_pins(cmd_e c, logic [4:0] p, pins_t cur, logic [7:0] tx);
    pins_t      r;
    logic [8:0] prod;
    logic [2:0] bit_q;
    logic [4:0] sub;
    r     = cur;
    // p / 3 for p below 24 via multiply by 11 and shift
    prod  = 9'(p) * 9'd11;
    bit_q = prod[7:5];
    sub   = p - (5'({bit_q, 1'b0}) + 5'(bit_q));
    case (c)
      CMD_START: begin
        if (p == 5'd0) begin
          r.scl = 1'b1;
          r.sda = 1'b1;
        end else if (p == 5'd1) begin
          r.sda = 1'b0;
        end else begin
          r.scl = 1'b0;
        end
      end
      CMD_STOP: begin
        if (p == 5'd0) r.scl = 1'b0;
        else if (p == 5'd1) r.sda = 1'b0;
        else if (p == 5'd2) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (p >= WRITE_BIT_PHASES) begin
          r.scl = 1'b0;
        end else if (sub == 5'd0) begin
          r.scl = 1'b0;
        end else if (sub == 5'd1) begin
          r.sda = tx[3'd7 - bit_q];
        end else begin
          r.scl = 1'b1;
        end
      end
      CMD_READ: begin
        if (!p[0]) begin
          if (p == 5'd0) r.sda = 1'b1;
          r.scl = 1'b0;
        end else begin
          r.scl = 1'b1;
        end
      end
      CMD_RDACK: r.scl = (p == 5'd1);
      CMD_ACK, CMD_NACK: begin
        if (p == 5'd0) r.scl = 1'b0;
        else if (p == 5'd1) r.sda = (c == CMD_NACK);
        else if (p == 5'd2) r.scl = 1'b1;
        else r.scl = 1'b0;
      end
      default: r = cur;
    endcase
    return r;
  endfunction

endpackage

### sv/i2c_master_bit_engine.sv
// i2c master bit engine: tick-driven command sequencer with skid-buffered result channel
//
// Usage: every accepted input item is one bus timing tick. It may carry a command
// (start, stop, write byte, read byte, read ack, send ack, send nack), the byte to
// write and the sampled SDA level. Each tick produces exactly one result item with
// the SCL and SDA drive levels, busy and done flags, the read shift register and
// the status code.
// The input channel takes an item on a clock edge with in_valid_i high and
// in_stall_o low; the result channel hands one over with out_valid_o high and
// out_stall_i low. The configuration channel writes the half period in ticks
// whenever cfg_valid_i is high; cfg_ready_o is always high.
// The result of an accepted item is registered in the output register, or in the skid
// register while the receiver stalls. Throughput: one item per cycle while in_stall_o
// is low, set by the combinational state update between the state and output registers.
// When the receiver stalls, a second result register holds one more item; only
// once both are full does in_stall_o rise, and it falls after one is taken.
// Reset clears the sequencer to idle with both pins released, the half period to
// 50 ticks and both result registers to empty.
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cm_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cm_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);

  logic [15:0]          half_q;
  i2cm_pkg::cmd_e       cmd_q, cmd_d;
  logic [4:0]           phase_q, phase_d;
  logic [15:0]          wait_q, wait_d;
  logic [7:0]           shift_q, shift_d;
  logic [7:0]           tx_q, tx_d;
  logic                 busy_q, busy_d;
  i2cm_pkg::pins_t      pins_q, pins_d;
  logic [1:0]           status_q, status_d;
  logic                 done;

  logic                 accept;
  logic [15:0]          reload;
  logic [15:0]          wait_dec;
  logic [4:0]           phase_nx;
  logic                 finish;
  i2cm_pkg::out_item_t  res;

  logic                 out_v_q, out_v_d;
  logic                 skid_v_q, skid_v_d;
  i2cm_pkg::out_item_t  out_q, out_d;
  i2cm_pkg::out_item_t  skid_q, skid_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_v_q;
  assign accept      = in_valid_i && !skid_v_q;
  assign reload      = (half_q == 16'd0) ? 16'd1 : half_q;
  assign wait_dec    = (wait_q != 16'd0) ? (wait_q - 16'd1) : wait_q;
  assign phase_nx    = phase_q + 5'd1;

  always_comb begin
    cmd_d    = cmd_q;
    phase_d  = phase_q;
    wait_d   = wait_q;
    shift_d  = shift_q;
    tx_d     = tx_q;
    busy_d   = busy_q;
    pins_d   = pins_q;
    status_d = status_q;
    done     = 1'b0;
    finish   = 1'b0;
    if (busy_q) begin
      wait_d = wait_dec;
      if (wait_dec == 16'd0) begin
        if (cmd_q == i2cm_pkg::CMD_START) begin
          if ((phase_q == 5'd0 && !in_item_i.sda_level) ||
              (phase_q == 5'd1 && in_item_i.sda_level)) begin
            status_d = i2cm_pkg::STATUS_START_FAIL;
            finish   = 1'b1;
          end
        end else if (cmd_q == i2cm_pkg::CMD_READ && phase_q[0]) begin
          shift_d = {shift_q[6:0], in_item_i.sda_level};
          if (phase_q == i2cm_pkg::READ_LAST_PHASE) begin
            pins_d.scl = 1'b0;
            finish     = 1'b1;
          end
        end else if (cmd_q == i2cm_pkg::CMD_RDACK && phase_q == 5'd1) begin
          if (in_item_i.sda_level) status_d = i2cm_pkg::STATUS_NACK;
        end
        if (phase_nx >= i2cm_pkg::phase_count(cmd_q)) finish = 1'b1;
        if (finish) begin
          busy_d  = 1'b0;
          done    = 1'b1;
          phase_d = 5'd0;
          wait_d  = 16'd0;
        end else begin
          phase_d = phase_nx;
          pins_d  = i2cm_pkg::apply_pins(cmd_q, phase_nx, pins_q, tx_q);
          wait_d  = reload;
        end
      end
    end else if (in_item_i.cmd_valid && in_item_i.cmd <= i2cm_pkg::CMD_NACK) begin
      cmd_d    = i2cm_pkg::cmd_e'(in_item_i.cmd);
      phase_d  = 5'd0;
      status_d = i2cm_pkg::STATUS_OK;
      busy_d   = 1'b1;
      if (in_item_i.cmd == i2cm_pkg::CMD_WRITE) tx_d = in_item_i.write_byte;
      if (in_item_i.cmd == i2cm_pkg::CMD_READ) shift_d = 8'd0;
      pins_d = i2cm_pkg::apply_pins(cmd_d, 5'd0, pins_q,
                                    (in_item_i.cmd == i2cm_pkg::CMD_WRITE) ?
                                    in_item_i.write_byte : tx_q);
      wait_d = reload;
    end
  end

  always_comb begin
    res.scl_drive = pins_d.scl;
    res.sda_drive = pins_d.sda;
    res.busy_res  = busy_d;
    res.done_res  = done;
    res.read_byte = shift_d;
    res.status    = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= i2cm_pkg::HALF_PERIOD_RESET;
      cmd_q    <= i2cm_pkg::CMD_START;
      phase_q  <= 5'd0;
      wait_q   <= 16'd0;
      shift_q  <= 8'd0;
      tx_q     <= 8'd0;
      busy_q   <= 1'b0;
      pins_q   <= '{scl: 1'b1, sda: 1'b1};
      status_q <= i2cm_pkg::STATUS_OK;
    end else begin
      if (cfg_valid_i) half_q <= cfg_data_i;
      if (accept) begin
        cmd_q    <= cmd_d;
        phase_q  <= phase_d;
        wait_q   <= wait_d;
        shift_q  <= shift_d;
        tx_q     <= tx_d;
        busy_q   <= busy_d;
        pins_q   <= pins_d;
        status_q <= status_d;
      end
    end
  end

  // output register plus skid register
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = res;
        out_v_d = accept;
      end
    end else if (accept) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  `ASSERT_CLK(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q)
  `ASSERT_CLK(a_idle_no_wait, clk_i, rst_ni, !busy_q |-> (wait_q == 16'd0))
  `ASSERT_NEVER(a_phase_range, clk_i, rst_ni, busy_q && (phase_q >= i2cm_pkg::phase_count(cmd_q)))
  `ASSERT_CLK(a_finish_releases, clk_i, rst_ni, (accept && busy_q && !busy_d) |=> (phase_q == 5'd0))

endmodule
